/* hw/rtl/ptar_pkg.sv */
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
package ptar_pkg;

  // Width of the fixed-point result field.
  localparam int unsigned OUT_W = 32;

  // Dividend bits retired per cycle by the remainder unit.
  localparam int unsigned DIV_BITS = 4;

  // First odd trial divisor and its square.
  localparam int unsigned FIRST_DIV    = 3;
  localparam int unsigned FIRST_DIV_SQ = FIRST_DIV * FIRST_DIV;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture the input item, reset the divisor
    logic start_div;   // begin a remainder for the current divisor
    logic div_step;    // retire DIV_BITS dividend bits
    logic next_div;    // advance to the next odd divisor
    logic start_sqrt;  // begin the square root
    logic sqrt_step;   // produce one root bit
    logic load_out;    // load the output register
    logic prime;       // primality verdict for the output register
  } ptar_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic le_one;       // value is zero or one
    logic is_two;       // value is two
    logic is_odd;       // value is odd
    logic dsq_gt_v;     // divisor squared exceeds the value
    logic div_last;     // current remainder step is the final one
    logic rem_zero_nxt; // remainder after this step is zero
    logic sqrt_last;    // current root step is the final one
  } ptar_sts_t;

endpackage

/* hw/rtl/ptar_ctrl.sv */
// Controller state machine sequencing the primality test and the root.
`timescale 1ns / 1ps
module ptar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ptar_pkg::ptar_sts_t sts_i,
  output ptar_pkg::ptar_cmd_t cmd_o
);
  import ptar_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;
  logic   out_valid_q, out_valid_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    prime_d = prime_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.le_one) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (sts_i.is_two) begin
          prime_d          = 1'b1;
          cmd_o.start_sqrt = 1'b1;
          state_d          = ST_SQRT;
        end else if (!sts_i.is_odd) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (sts_i.dsq_gt_v) begin
          // No divisor up to the square root divides the value.
          prime_d          = 1'b1;
          cmd_o.start_sqrt = 1'b1;
          state_d          = ST_SQRT;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          if (sts_i.rem_zero_nxt) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            cmd_o.next_div = 1'b1;
            state_d        = ST_CHECK;
          end
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.prime = prime_q;
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prime_q     <= prime_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/ptar_dp.sv */
// Datapath: operand registers, trial divisor, remainder unit, root unit, output register.
`timescale 1ns / 1ps
module ptar_dp #(
  parameter int unsigned VALUE_WIDTH = 22,
  parameter int unsigned FRAC_BITS   = 10
) (
  input  logic                       clk_i,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  input  logic                       is_last_i,
  input  ptar_pkg::ptar_cmd_t        cmd_i,
  output ptar_pkg::ptar_sts_t        sts_o,
  output logic [ptar_pkg::OUT_W-1:0] out_value_o,
  output logic                       is_prime_o,
  output logic                       out_last_o
);
  import ptar_pkg::*;

  // Derived widths.
  localparam int unsigned XW    = VALUE_WIDTH + 2 * FRAC_BITS;  // root operand
  localparam int unsigned RW    = (XW + 1) / 2;                 // root width
  localparam int unsigned SW    = 2 * RW;                       // padded root operand
  localparam int unsigned DW    = VALUE_WIDTH / 2 + 2;          // trial divisor
  localparam int unsigned QW    = VALUE_WIDTH + 2;              // divisor squared
  localparam int unsigned NB    = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DVW   = NB * DIV_BITS;                // padded dividend
  localparam int unsigned PW    = VALUE_WIDTH + FRAC_BITS + OUT_W;
  localparam int unsigned CNT_W = (RW > 1) ? $clog2(RW) : 1;

  logic [VALUE_WIDTH-1:0] v_q;
  logic                   last_q;
  logic [DW-1:0]          d_q;
  logic [QW-1:0]          dsq_q;
  logic [DVW-1:0]         dvd_q;
  logic [DW-1:0]          rem_q, rem_nxt;
  logic [DW:0]            rem_t;
  logic [SW-1:0]          sx_q;
  logic [RW:0]            srem_q, srem_nxt;
  logic [RW+2:0]          sq_t, sq_trial;
  logic [RW-1:0]          root_q, root_nxt;
  logic [CNT_W-1:0]       cnt_q;
  logic [PW-1:0]          pass_val;
  logic [OUT_W-1:0]       out_value_q;
  logic                   is_prime_q;
  logic                   out_last_q;

  // Remainder unit: DIV_BITS restoring steps per cycle, dividend MSB first.
  always_comb begin
    rem_nxt = rem_q;
    rem_t   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_t = {rem_nxt, dvd_q[DVW-1-i]};
      if (rem_t >= {1'b0, d_q}) begin
        rem_t = rem_t - {1'b0, d_q};
      end
      rem_nxt = rem_t[DW-1:0];
    end
  end

  // Root unit: one result bit per cycle. The partial remainder can reach
  // twice the partial root, so it keeps one bit more than the root.
  always_comb begin
    sq_t     = {srem_q, sx_q[SW-1 -: 2]};
    sq_trial = {1'b0, root_q, 2'b01};
    if (sq_t >= sq_trial) begin
      srem_nxt = (RW+1)'(sq_t - sq_trial);
      root_nxt = {root_q[RW-2:0], 1'b1};
    end else begin
      srem_nxt = sq_t[RW:0];
      root_nxt = {root_q[RW-2:0], 1'b0};
    end
  end

  // Scaled pass-through value, wrapped to the result width.
  assign pass_val = PW'(v_q) << FRAC_BITS;

  // Operand, divisor and iteration registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q    <= value_i;
      last_q <= is_last_i;
      d_q    <= DW'(FIRST_DIV);
      dsq_q  <= QW'(FIRST_DIV_SQ);
    end
    if (cmd_i.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_q   <= d_q + DW'(2);
      dsq_q <= dsq_q + QW'({d_q, 2'b00}) + QW'(4);
    end
    if (cmd_i.start_div) begin
      dvd_q <= DVW'(v_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << DIV_BITS;
      rem_q <= rem_nxt;
    end
    if (cmd_i.start_sqrt) begin
      sx_q   <= SW'(v_q) << (2 * FRAC_BITS);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sx_q   <= sx_q << 2;
      srem_q <= srem_nxt;
      root_q <= root_nxt;
    end
    if (cmd_i.start_div || cmd_i.start_sqrt) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= cmd_i.prime ? OUT_W'(root_q) : pass_val[OUT_W-1:0];
      is_prime_q  <= cmd_i.prime;
      out_last_q  <= last_q;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o.le_one       = (v_q[VALUE_WIDTH-1:1] == '0);
    sts_o.is_two       = (v_q == VALUE_WIDTH'(2));
    sts_o.is_odd       = v_q[0];
    sts_o.dsq_gt_v     = (dsq_q > QW'(v_q));
    sts_o.div_last     = (cnt_q == CNT_W'(NB - 1));
    sts_o.rem_zero_nxt = (rem_nxt == '0);
    sts_o.sqrt_last    = (cnt_q == CNT_W'(RW - 1));
  end

  assign out_value_o = out_value_q;
  assign is_prime_o  = is_prime_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/prime_test_and_root_top.sv */
// Top level of the trial-division primality test with square root of primes.
`timescale 1ns / 1ps
// Each transfer on the input channel carries one unsigned value and a last
// marker; each produces exactly one output transfer in order. A prime value
// returns floor(sqrt(value) * 2^FRAC_BITS) with is_prime set; any other value
// returns value * 2^FRAC_BITS (wrapped to 32 bits). One item is in work at a
// time. After its input transfer an item is checked; an odd value above two
// is tried against the odd trial divisors up to its square root in the
// remainder unit until one divides it, and a prime value then passes through
// the bit-serial root unit before its result is ready; intake reopens once
// that result is loaded into the output register. A finished result waits in
// the output register while the next item is taken in; a further result is
// held back until that register empties.
module prime_test_and_root_top #(
  parameter int unsigned VALUE_WIDTH = 22,
  parameter int unsigned FRAC_BITS   = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  input  logic                       is_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ptar_pkg::OUT_W-1:0] out_value_o,
  output logic                       is_prime_o,
  output logic                       out_last_o
);
  import ptar_pkg::*;

  ptar_cmd_t cmd;
  ptar_sts_t sts;

  // Sequencer.
  ptar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and result storage.
  ptar_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .is_last_i   (is_last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_value_o (out_value_o),
    .is_prime_o  (is_prime_o),
    .out_last_o  (out_last_o)
  );

  // Only one item is in work: intake closes after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten before transfer");

  // Trial division only runs while the divisor squared is within the value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !sts.dsq_gt_v)
    else $error("remainder step with divisor beyond the square root");

  // The root of a prime is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_prime_o) |-> (out_value_o != '0))
    else $error("zero root reported for a prime");

endmodule
